// File: hdl/pac_pkg.sv
// shared types, constants and codes of the packet acl classifier
package pac_pkg;

  localparam int PAC_RULE_ENTRIES = 64;
  localparam int PAC_LIST_ENTRIES = 32;

  localparam int KIND_W   = 2;
  localparam int ADDR_W   = 32;
  localparam int PROTO_W  = 8;
  localparam int PORT_W   = 16;
  localparam int RIDX_W   = 6;
  localparam int RPROTO_W = 2;
  localparam int SRC_W    = 2;
  localparam int MATCH_W  = 6;
  localparam int RCNT_W   = 7;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_CLASSIFY  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RULE_WR   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ALLOW_ADD = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BLOCK_ADD = 2'd3;

  // rule protocol codes
  localparam logic [RPROTO_W-1:0] RPROTO_ANY   = 2'd0;
  localparam logic [RPROTO_W-1:0] RPROTO_TCP   = 2'd1;
  localparam logic [RPROTO_W-1:0] RPROTO_UDP   = 2'd2;
  localparam logic [RPROTO_W-1:0] RPROTO_NEVER = 2'd3;

  // ip protocol numbers
  localparam logic [PROTO_W-1:0] IP_PROTO_TCP = 8'd6;
  localparam logic [PROTO_W-1:0] IP_PROTO_UDP = 8'd17;

  // decision sources
  localparam logic [SRC_W-1:0] DEC_ALLOW_LIST = 2'd0;
  localparam logic [SRC_W-1:0] DEC_BLOCK_LIST = 2'd1;
  localparam logic [SRC_W-1:0] DEC_RULE       = 2'd2;
  localparam logic [SRC_W-1:0] DEC_DEFAULT    = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [ADDR_W-1:0]   src_addr;
    logic [ADDR_W-1:0]   dst_addr;
    logic [PROTO_W-1:0]  protocol;
    logic [PORT_W-1:0]   dst_port;
    logic [RIDX_W-1:0]   rule_index;
    logic                rule_allow;
    logic [RPROTO_W-1:0] rule_proto;
    logic                rule_src_any;
    logic                rule_dst_any;
  } pac_in_t;

  typedef struct packed {
    logic               allowed;
    logic [SRC_W-1:0]   decision_source;
    logic [MATCH_W-1:0] matched_rule;
    logic               status;
  } pac_out_t;

  // packet header as broadcast to the rule cells
  typedef struct packed {
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic [PORT_W-1:0] dst_port;
    logic              is_tcp;
    logic              is_udp;
  } pac_key_t;

  // one stored rule
  typedef struct packed {
    logic [ADDR_W-1:0]   src_addr;
    logic [ADDR_W-1:0]   dst_addr;
    logic [PORT_W-1:0]   dst_port;
    logic [RPROTO_W-1:0] proto;
    logic                allow;
    logic                src_any;
    logic                dst_any;
  } pac_rule_t;

  // token walking down the rule chain
  typedef struct packed {
    logic               valid;
    logic               hit;
    logic               allow;
    logic [MATCH_W-1:0] idx;
  } pac_rtok_t;

  // token walking down a list chain
  typedef struct packed {
    logic valid;
    logic hit;
  } pac_ltok_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } pac_state_e;

endpackage

// File: hdl/packet_acl_classifier_top.sv
// top level of the first-match acl packet classifier
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+----------------------------
//  in       | input     | in_valid_i / in_stall_o   | in_item_i  (pac_in_t)
//  out      | output    | out_valid_o / out_stall_i | out_item_o (pac_out_t)
//  cfg      | input     | cfg_we_i                  | cfg_wdata_i (rule_count)
//
// one item at a time; the result is loaded in the done state, which follows the scan
// of the longest cell chain by the token (one cell per cycle), and the next item can
// be taken in the cycle after the result is loaded
// reset clears the fill counts, rule_count and all control state; stored
// rules and list addresses hold garbage until written
// the result sits in an output register, so the next item is taken while it
// waits; a stalled result only holds up the following item at its finish
module packet_acl_classifier_top
  import pac_pkg::*;
#(
  parameter int RULE_ENTRIES = PAC_RULE_ENTRIES,
  parameter int LIST_ENTRIES = PAC_LIST_ENTRIES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pac_in_t           in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pac_out_t          out_item_o,
  input  logic              cfg_we_i,
  input  logic [RCNT_W-1:0] cfg_wdata_i
);

  localparam int SCAN_LEN = (RULE_ENTRIES > LIST_ENTRIES) ? RULE_ENTRIES : LIST_ENTRIES;
  localparam int CNT_W    = $clog2(SCAN_LEN + 1);
  localparam int FILL_W   = $clog2(LIST_ENTRIES + 1);

  // control state
  pac_state_e        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q;
  logic              inj_q;
  logic [RCNT_W-1:0] rule_count_q;
  logic [FILL_W-1:0] allow_fill_q;
  logic [FILL_W-1:0] block_fill_q;
  logic              out_valid_q;

  // payload
  pac_in_t           item_q;
  pac_out_t          out_q;

  pac_key_t          key;
  pac_rule_t         wr_rule;
  logic              in_acc;
  logic              rule_wr;
  logic              finish;
  logic              allow_wr;
  logic              block_wr;
  logic              scan_end;
  pac_out_t          result;

  // token chains; entry 0 is the injected token
  pac_rtok_t rtok [RULE_ENTRIES+1];
  pac_ltok_t atok [LIST_ENTRIES+1];
  pac_ltok_t btok [LIST_ENTRIES+1];

  assign in_acc   = in_valid_i && !in_stall_o;
  assign rule_wr  = in_acc && (in_item_i.kind == KIND_RULE_WR);
  assign scan_end = (cnt_q == CNT_W'(SCAN_LEN - 1));

  // header broadcast to every rule cell
  always_comb begin
    key.src_addr = item_q.src_addr;
    key.dst_addr = item_q.dst_addr;
    key.dst_port = item_q.dst_port;
    key.is_tcp   = (item_q.protocol == IP_PROTO_TCP);
    key.is_udp   = (item_q.protocol == IP_PROTO_UDP);
  end

  // rule writes go straight into the addressed cell at acceptance
  always_comb begin
    wr_rule.src_addr = in_item_i.src_addr;
    wr_rule.dst_addr = in_item_i.dst_addr;
    wr_rule.dst_port = in_item_i.dst_port;
    wr_rule.proto    = in_item_i.rule_proto;
    wr_rule.allow    = in_item_i.rule_allow;
    wr_rule.src_any  = in_item_i.rule_src_any;
    wr_rule.dst_any  = in_item_i.rule_dst_any;
  end

  assign rtok[0] = '{valid: inj_q, hit: 1'b0, allow: 1'b0, idx: '0};
  assign atok[0] = '{valid: inj_q, hit: 1'b0};
  assign btok[0] = '{valid: inj_q, hit: 1'b0};

  for (genvar g = 0; g < RULE_ENTRIES; g++) begin : g_rule
    pac_rule_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .key_i        (key),
      .rule_count_i (rule_count_q),
      .wr_en_i      (rule_wr),
      .wr_idx_i     (in_item_i.rule_index),
      .wr_rule_i    (wr_rule),
      .tok_i        (rtok[g]),
      .tok_o        (rtok[g+1])
    );
  end

  for (genvar g = 0; g < LIST_ENTRIES; g++) begin : g_list
    pac_list_cell #(
      .CELL_IDX (g),
      .FILL_W   (FILL_W)
    ) u_allow (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .key_i     (item_q.src_addr),
      .fill_i    (allow_fill_q),
      .wr_en_i   (allow_wr),
      .wr_addr_i (item_q.src_addr),
      .tok_i     (atok[g]),
      .tok_o     (atok[g+1])
    );

    pac_list_cell #(
      .CELL_IDX (g),
      .FILL_W   (FILL_W)
    ) u_block (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .key_i     (item_q.src_addr),
      .fill_i    (block_fill_q),
      .wr_en_i   (block_wr),
      .wr_addr_i (item_q.src_addr),
      .tok_i     (btok[g]),
      .tok_o     (btok[g+1])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer; chain ends hold their last token data here
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    finish     = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
    result     = '0;
    allow_wr   = 1'b0;
    block_wr   = 1'b0;
    case (item_q.kind)
      KIND_CLASSIFY: begin
        if (atok[LIST_ENTRIES].hit) begin
          result.allowed         = 1'b1;
          result.decision_source = DEC_ALLOW_LIST;
        end else if (btok[LIST_ENTRIES].hit) begin
          result.decision_source = DEC_BLOCK_LIST;
        end else if (rtok[RULE_ENTRIES].hit) begin
          result.allowed         = rtok[RULE_ENTRIES].allow;
          result.decision_source = DEC_RULE;
          result.matched_rule    = rtok[RULE_ENTRIES].idx;
        end else begin
          result.decision_source = DEC_DEFAULT;
        end
      end
      KIND_RULE_WR: begin
        result = '0;
      end
      KIND_ALLOW_ADD: begin
        if (!atok[LIST_ENTRIES].hit) begin
          if (allow_fill_q == FILL_W'(LIST_ENTRIES)) begin
            result.status = 1'b1;
          end else begin
            allow_wr = finish;
          end
        end
      end
      KIND_BLOCK_ADD: begin
        if (!btok[LIST_ENTRIES].hit) begin
          if (block_fill_q == FILL_W'(LIST_ENTRIES)) begin
            result.status = 1'b1;
          end else begin
            block_wr = finish;
          end
        end
      end
      default: result = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      inj_q        <= 1'b0;
      rule_count_q <= '0;
      allow_fill_q <= '0;
      block_fill_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      inj_q   <= in_acc;
      if (in_acc) begin
        cnt_q <= '0;
      end else if (state_q == ST_SCAN) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cfg_we_i) begin
        rule_count_q <= cfg_wdata_i;
      end
      if (allow_wr) begin
        allow_fill_q <= allow_fill_q + FILL_W'(1);
      end
      if (block_wr) begin
        block_fill_q <= block_fill_q + FILL_W'(1);
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_item_i;
    end
    if (finish) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: hdl/pac_rule_cell.sv
// one rule table entry with its match logic and token stage
module pac_rule_cell
  import pac_pkg::*;
#(
  parameter int CELL_IDX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pac_key_t            key_i,
  input  logic [RCNT_W-1:0]   rule_count_i,
  input  logic                wr_en_i,
  input  logic [RIDX_W-1:0]   wr_idx_i,
  input  pac_rule_t           wr_rule_i,
  input  pac_rtok_t           tok_i,
  output pac_rtok_t           tok_o
);

  pac_rule_t rule_q;
  logic      tok_valid_q;
  logic      tok_hit_q;
  logic      tok_allow_q;
  logic [MATCH_W-1:0] tok_idx_q;

  logic in_use;
  logic src_ok;
  logic dst_ok;
  logic proto_ok;
  logic port_ok;
  logic match;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (int'(wr_idx_i) == CELL_IDX)) begin
      rule_q <= wr_rule_i;
    end
  end

  always_comb begin
    in_use = (CELL_IDX < int'(rule_count_i));
    src_ok = rule_q.src_any || (rule_q.src_addr == key_i.src_addr);
    dst_ok = rule_q.dst_any || (rule_q.dst_addr == key_i.dst_addr);
    case (rule_q.proto)
      RPROTO_ANY:   proto_ok = 1'b1;
      RPROTO_TCP:   proto_ok = key_i.is_tcp;
      RPROTO_UDP:   proto_ok = key_i.is_udp;
      RPROTO_NEVER: proto_ok = 1'b0;
      default:      proto_ok = 1'b0;
    endcase
    port_ok = (rule_q.dst_port == '0) ||
              ((key_i.is_tcp || key_i.is_udp) && (rule_q.dst_port == key_i.dst_port));
    match = in_use && src_ok && dst_ok && proto_ok && port_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_i.valid;
    end
  end

  // earlier hit wins, otherwise this entry may claim the decision
  always_ff @(posedge clk_i) begin
    if (tok_i.valid) begin
      if (tok_i.hit || !match) begin
        tok_hit_q   <= tok_i.hit;
        tok_allow_q <= tok_i.allow;
        tok_idx_q   <= tok_i.idx;
      end else begin
        tok_hit_q   <= 1'b1;
        tok_allow_q <= rule_q.allow;
        tok_idx_q   <= MATCH_W'(CELL_IDX);
      end
    end
  end

  assign tok_o = '{valid: tok_valid_q, hit: tok_hit_q, allow: tok_allow_q, idx: tok_idx_q};

endmodule

// File: hdl/pac_list_cell.sv
// one address list entry with its compare and token stage
module pac_list_cell
  import pac_pkg::*;
#(
  parameter int CELL_IDX = 0,
  parameter int FILL_W   = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ADDR_W-1:0] key_i,
  input  logic [FILL_W-1:0] fill_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  pac_ltok_t         tok_i,
  output pac_ltok_t         tok_o
);

  logic [ADDR_W-1:0] addr_q;
  logic              tok_valid_q;
  logic              tok_hit_q;
  logic              hit;

  // new entries always land at the fill position
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (int'(fill_i) == CELL_IDX)) begin
      addr_q <= wr_addr_i;
    end
  end

  assign hit = (CELL_IDX < int'(fill_i)) && (addr_q == key_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_i.valid) begin
      tok_hit_q <= tok_i.hit || hit;
    end
  end

  assign tok_o = '{valid: tok_valid_q, hit: tok_hit_q};

endmodule
